[hw/rtl/hsbr_pkg.sv]
// Shared types and constants for the handshaked serial byte receiver.
package hsbr_pkg;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_WAIT_REQ   = 4'd1,
    PH_HS_LOW     = 4'd2,
    PH_WAIT_FIRST = 4'd3,
    PH_BIT_START  = 4'd4,
    PH_BIT_END    = 4'd5,
    PH_PAR_START  = 4'd6,
    PH_PAR_END    = 4'd7,
    PH_ACK        = 4'd8
  } hsbr_phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_PARITY_ERR   = 3'd1,
    ST_NO_REQUEST   = 3'd2,
    ST_NO_FIRST_BIT = 3'd3,
    ST_NO_BIT_START = 3'd4,
    ST_NO_BIT_END   = 3'd5,
    ST_NO_PARITY    = 3'd6,
    ST_NO_END       = 3'd7
  } hsbr_status_t;

  localparam logic CFG_TIMEOUT_RELOAD = 1'b0;
  localparam logic CFG_ACK_LOW_TICKS  = 1'b1;

  typedef struct packed {
    logic start_req;
    logic clock_level;
    logic data_level;
  } hsbr_tick_t;

  typedef struct packed {
    logic         data_drive_low;
    logic         clock_drive_enable;
    logic         clock_drive_value;
    logic         done_res;
    logic [7:0]   received_byte;
    hsbr_status_t status;
    logic [7:0]   parity_error_count;
    logic         busy_res;
  } hsbr_result_t;

endpackage

[hw/rtl/hsbr_core.sv]
// Receiver state machine: one tick in, one result out, state advanced per step.
module hsbr_core #(
  parameter int DATA_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  hsbr_pkg::hsbr_tick_t  tick,
  input  logic [7:0]            timeout_reload,
  input  logic [7:0]            ack_low_ticks,
  output hsbr_pkg::hsbr_result_t res
);

  localparam logic [2:0] LastBit = 3'(DATA_BITS - 1);

  hsbr_pkg::hsbr_phase_t phase_r, phase_nxt;
  logic [7:0] wait_counter_r, wait_counter_nxt;
  logic [2:0] bit_index_r, bit_index_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic       running_parity_r, running_parity_nxt;
  logic       parity_mismatch_r, parity_mismatch_nxt;
  logic [7:0] error_tally_r, error_tally_nxt;

  logic [7:0] ack_len;
  logic       want_high;
  logic       met;
  logic       expired;
  logic       ack_last;

  assign ack_len  = (ack_low_ticks == 8'd0) ? 8'd1 : ack_low_ticks;
  assign met      = (tick.clock_level == want_high);
  assign expired  = (wait_counter_r == 8'd0);
  assign ack_last = (wait_counter_r <= 8'd1);

  always_comb begin
    unique case (phase_r)
      hsbr_pkg::PH_WAIT_FIRST,
      hsbr_pkg::PH_BIT_END,
      hsbr_pkg::PH_PAR_END: want_high = 1'b1;
      default:              want_high = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt           = phase_r;
    wait_counter_nxt    = wait_counter_r;
    bit_index_nxt       = bit_index_r;
    shift_byte_nxt      = shift_byte_r;
    running_parity_nxt  = running_parity_r;
    parity_mismatch_nxt = parity_mismatch_r;
    error_tally_nxt     = error_tally_r;
    unique case (phase_r)
      hsbr_pkg::PH_IDLE: begin
        if (tick.start_req) begin
          phase_nxt           = hsbr_pkg::PH_WAIT_REQ;
          wait_counter_nxt    = timeout_reload;
          bit_index_nxt       = 3'd0;
          shift_byte_nxt      = 8'd0;
          running_parity_nxt  = 1'b0;
          parity_mismatch_nxt = 1'b0;
        end
      end
      hsbr_pkg::PH_HS_LOW,
      hsbr_pkg::PH_ACK: begin
        if (ack_last) begin
          phase_nxt        = (phase_r == hsbr_pkg::PH_ACK) ? hsbr_pkg::PH_IDLE
                                                           : hsbr_pkg::PH_WAIT_FIRST;
          wait_counter_nxt = timeout_reload;
        end else begin
          wait_counter_nxt = wait_counter_r - 8'd1;
        end
      end
      hsbr_pkg::PH_WAIT_REQ,
      hsbr_pkg::PH_WAIT_FIRST,
      hsbr_pkg::PH_BIT_START,
      hsbr_pkg::PH_BIT_END,
      hsbr_pkg::PH_PAR_START,
      hsbr_pkg::PH_PAR_END: begin
        if (met) begin
          wait_counter_nxt = timeout_reload;
          unique case (phase_r)
            hsbr_pkg::PH_WAIT_REQ: begin
              phase_nxt        = hsbr_pkg::PH_HS_LOW;
              wait_counter_nxt = ack_len;
            end
            hsbr_pkg::PH_WAIT_FIRST: begin
              phase_nxt     = hsbr_pkg::PH_BIT_START;
              bit_index_nxt = 3'd0;
            end
            hsbr_pkg::PH_BIT_START: begin
              shift_byte_nxt[bit_index_r] = shift_byte_r[bit_index_r] | tick.data_level;
              running_parity_nxt          = running_parity_r ^ tick.data_level;
              phase_nxt                   = hsbr_pkg::PH_BIT_END;
            end
            hsbr_pkg::PH_BIT_END: begin
              if (bit_index_r >= LastBit) begin
                phase_nxt = hsbr_pkg::PH_PAR_START;
              end else begin
                bit_index_nxt = bit_index_r + 3'd1;
                phase_nxt     = hsbr_pkg::PH_BIT_START;
              end
            end
            hsbr_pkg::PH_PAR_START: begin
              parity_mismatch_nxt = (tick.data_level != running_parity_r);
              phase_nxt           = hsbr_pkg::PH_PAR_END;
            end
            default: begin
              if (parity_mismatch_r) error_tally_nxt = error_tally_r + 8'd1;
              phase_nxt        = hsbr_pkg::PH_ACK;
              wait_counter_nxt = ack_len;
            end
          endcase
        end else if (expired) begin
          phase_nxt = hsbr_pkg::PH_IDLE;
        end else begin
          wait_counter_nxt = wait_counter_r - 8'd1;
        end
      end
      default: phase_nxt = hsbr_pkg::PH_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    res                    = '0;
    res.status             = hsbr_pkg::ST_OK;
    res.parity_error_count = error_tally_nxt;
    res.busy_res           = (phase_nxt != hsbr_pkg::PH_IDLE);
    unique case (phase_r)
      hsbr_pkg::PH_HS_LOW: res.data_drive_low = 1'b1;
      hsbr_pkg::PH_ACK: begin
        res.data_drive_low     = 1'b1;
        res.clock_drive_enable = 1'b1;
        res.clock_drive_value  = !parity_mismatch_r;
        if (ack_last) begin
          res.done_res      = 1'b1;
          res.received_byte = shift_byte_r;
          res.status        = parity_mismatch_r ? hsbr_pkg::ST_PARITY_ERR : hsbr_pkg::ST_OK;
        end
      end
      hsbr_pkg::PH_WAIT_REQ,
      hsbr_pkg::PH_WAIT_FIRST,
      hsbr_pkg::PH_BIT_START,
      hsbr_pkg::PH_BIT_END,
      hsbr_pkg::PH_PAR_START,
      hsbr_pkg::PH_PAR_END: begin
        if (!met && expired) begin
          res.done_res = 1'b1;
          unique case (phase_r)
            hsbr_pkg::PH_WAIT_REQ:   res.status = hsbr_pkg::ST_NO_REQUEST;
            hsbr_pkg::PH_WAIT_FIRST: res.status = hsbr_pkg::ST_NO_FIRST_BIT;
            hsbr_pkg::PH_BIT_START:  res.status = hsbr_pkg::ST_NO_BIT_START;
            hsbr_pkg::PH_BIT_END:    res.status = hsbr_pkg::ST_NO_BIT_END;
            hsbr_pkg::PH_PAR_START:  res.status = hsbr_pkg::ST_NO_PARITY;
            default:                 res.status = hsbr_pkg::ST_NO_END;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= hsbr_pkg::PH_IDLE;
      wait_counter_r    <= 8'd0;
      bit_index_r       <= 3'd0;
      shift_byte_r      <= 8'd0;
      running_parity_r  <= 1'b0;
      parity_mismatch_r <= 1'b0;
      error_tally_r     <= 8'd0;
    end else if (step) begin
      phase_r           <= phase_nxt;
      wait_counter_r    <= wait_counter_nxt;
      bit_index_r       <= bit_index_nxt;
      shift_byte_r      <= shift_byte_nxt;
      running_parity_r  <= running_parity_nxt;
      parity_mismatch_r <= parity_mismatch_nxt;
      error_tally_r     <= error_tally_nxt;
    end
  end

  a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(wait_counter_r) && $stable(error_tally_r))
    else $error("receiver state moved without a step");

  a_tally_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (error_tally_r == $past(error_tally_r)) ||
             (error_tally_r == $past(error_tally_r) + 8'd1))
    else $error("parity error tally jumped");

  a_done_ends_attempt: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == hsbr_pkg::PH_IDLE)
    else $error("attempt reported done but did not return to idle");

  a_ack_drives_clock: assert property (@(posedge clk) disable iff (!rst_n)
    res.clock_drive_enable |-> res.data_drive_low && phase_r == hsbr_pkg::PH_ACK)
    else $error("clock driven outside acknowledge");

endmodule

[hw/rtl/handshake_serial_byte_receiver.sv]
// Top level of the handshaked serial byte receiver: beat registers and config.
// Each input beat is one sample tick of the clock and data lines plus a start
// pulse; each tick yields exactly one result beat carrying the line drives,
// the done flag, status, byte and parity error count. The block takes one
// tick per cycle: a tick passes from the input register through the receiver
// state machine into the result register, so the rate is one beat per cycle,
// limited only by out_ready. Configuration (timeout_reload at index 0,
// ack_low_ticks at index 1) is to be written through the cfg port while the
// block is idle; the block itself does not enforce this.
module handshake_serial_byte_receiver #(
  parameter int DATA_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_start_req,
  input  logic       in_clock_level,
  input  logic       in_data_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_data_drive_low,
  output logic       out_clock_drive_enable,
  output logic       out_clock_drive_value,
  output logic       out_done_res,
  output logic [7:0] out_received_byte,
  output logic [2:0] out_status,
  output logic [7:0] out_parity_error_count,
  output logic       out_busy_res
);

  logic [7:0] timeout_reload_r;
  logic [7:0] ack_low_ticks_r;

  logic                   in_valid_r;
  hsbr_pkg::hsbr_tick_t   in_tick_r;
  logic                   out_valid_r;
  hsbr_pkg::hsbr_result_t out_res_r;
  hsbr_pkg::hsbr_result_t core_res;

  logic out_free;
  logic advance;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_reload_r <= 8'd255;
      ack_low_ticks_r  <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsbr_pkg::CFG_TIMEOUT_RELOAD: timeout_reload_r <= cfg_wdata;
        hsbr_pkg::CFG_ACK_LOW_TICKS:  ack_low_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage: hold the tick until the state machine can take it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_tick_r.start_req   <= in_start_req;
      in_tick_r.clock_level <= in_clock_level;
      in_tick_r.data_level  <= in_data_level;
    end
  end

  hsbr_core #(
    .DATA_BITS(DATA_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .tick          (in_tick_r),
    .timeout_reload(timeout_reload_r),
    .ack_low_ticks (ack_low_ticks_r),
    .res           (core_res)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data_drive_low     = out_res_r.data_drive_low;
  assign out_clock_drive_enable = out_res_r.clock_drive_enable;
  assign out_clock_drive_value  = out_res_r.clock_drive_value;
  assign out_done_res           = out_res_r.done_res;
  assign out_received_byte      = out_res_r.received_byte;
  assign out_status             = out_res_r.status;
  assign out_parity_error_count = out_res_r.parity_error_count;
  assign out_busy_res           = out_res_r.busy_res;

endmodule

[tb/handshake_serial_byte_receiver_tb.sv]
// Testbench for the handshaked serial byte receiver: line-level stimulus, scoreboard check.
`timescale 1ns / 100ps

module handshake_serial_byte_receiver_tb;

  localparam int DATA_BITS   = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  // Predicts one result beat per accepted tick and checks result beats in order.
  class rx_byte_scoreboard #(int NBITS = 8);
    typedef enum {W_HOLD, W_MET, W_EXPIRED} wait_res_t;

    logic [7:0]             tmo_reload;
    logic [7:0]             ack_ticks;
    hsbr_pkg::hsbr_phase_t  phase;
    logic [7:0]             wait_cnt;
    logic [2:0]             bit_idx;
    logic [7:0]             shift_byte;
    logic                   run_par;
    logic                   par_bad;
    logic [7:0]             err_tally;
    hsbr_pkg::hsbr_result_t pending_q[$];
    int                     errors;
    int                     beats_checked;

    function new();
      tmo_reload    = 8'd255;
      ack_ticks     = 8'd10;
      phase         = hsbr_pkg::PH_IDLE;
      wait_cnt      = '0;
      bit_idx       = '0;
      shift_byte    = '0;
      run_par       = 1'b0;
      par_bad       = 1'b0;
      err_tally     = '0;
      errors        = 0;
      beats_checked = 0;
    endfunction

    function void set_config(logic idx, logic [7:0] val);
      if (idx == hsbr_pkg::CFG_TIMEOUT_RELOAD) begin
        tmo_reload = val;
      end else begin
        ack_ticks = val;
      end
    endfunction

    function int pending_count();
      return pending_q.size();
    endfunction

    function bit busy();
      return phase != hsbr_pkg::PH_IDLE;
    endfunction

    // Clock level that does not satisfy the current wait, so an attempt runs out.
    function bit stall_level();
      case (phase)
        hsbr_pkg::PH_WAIT_FIRST, hsbr_pkg::PH_BIT_END, hsbr_pkg::PH_PAR_END: return 1'b0;
        default: return 1'b1;
      endcase
    endfunction

    function wait_res_t wait_step(bit met);
      if (met) return W_MET;
      if (wait_cnt == 0) return W_EXPIRED;
      wait_cnt = wait_cnt - 8'd1;
      return W_HOLD;
    endfunction

    function void note_tick(bit start, bit clk_lv, bit dat);
      hsbr_pkg::hsbr_result_t r;
      wait_res_t              w;
      logic [7:0]             ack_len;
      hsbr_pkg::hsbr_status_t abort_code;
      bit                     aborted;
      r          = '0;
      w          = W_HOLD;
      aborted    = 1'b0;
      abort_code = hsbr_pkg::ST_OK;
      ack_len    = (ack_ticks == 0) ? 8'd1 : ack_ticks;
      case (phase)
        hsbr_pkg::PH_IDLE: begin
          if (start) begin
            phase      = hsbr_pkg::PH_WAIT_REQ;
            wait_cnt   = tmo_reload;
            bit_idx    = '0;
            shift_byte = '0;
            run_par    = 1'b0;
            par_bad    = 1'b0;
          end
        end
        hsbr_pkg::PH_WAIT_REQ: begin
          w = wait_step(!clk_lv);
          if (w == W_MET) begin
            phase    = hsbr_pkg::PH_HS_LOW;
            wait_cnt = ack_len;
          end
          abort_code = hsbr_pkg::ST_NO_REQUEST;
        end
        hsbr_pkg::PH_HS_LOW: begin
          r.data_drive_low = 1'b1;
          if (wait_cnt <= 1) begin
            phase    = hsbr_pkg::PH_WAIT_FIRST;
            wait_cnt = tmo_reload;
          end else begin
            wait_cnt = wait_cnt - 8'd1;
          end
        end
        hsbr_pkg::PH_WAIT_FIRST: begin
          w = wait_step(clk_lv);
          if (w == W_MET) begin
            phase    = hsbr_pkg::PH_BIT_START;
            wait_cnt = tmo_reload;
            bit_idx  = '0;
          end
          abort_code = hsbr_pkg::ST_NO_FIRST_BIT;
        end
        hsbr_pkg::PH_BIT_START: begin
          w = wait_step(!clk_lv);
          if (w == W_MET) begin
            shift_byte = shift_byte | (8'(dat) << bit_idx);
            run_par    = run_par ^ dat;
            phase      = hsbr_pkg::PH_BIT_END;
            wait_cnt   = tmo_reload;
          end
          abort_code = hsbr_pkg::ST_NO_BIT_START;
        end
        hsbr_pkg::PH_BIT_END: begin
          w = wait_step(clk_lv);
          if (w == W_MET) begin
            if (bit_idx >= 3'(NBITS - 1)) begin
              phase = hsbr_pkg::PH_PAR_START;
            end else begin
              bit_idx = bit_idx + 3'd1;
              phase   = hsbr_pkg::PH_BIT_START;
            end
            wait_cnt = tmo_reload;
          end
          abort_code = hsbr_pkg::ST_NO_BIT_END;
        end
        hsbr_pkg::PH_PAR_START: begin
          w = wait_step(!clk_lv);
          if (w == W_MET) begin
            par_bad  = (dat != run_par);
            phase    = hsbr_pkg::PH_PAR_END;
            wait_cnt = tmo_reload;
          end
          abort_code = hsbr_pkg::ST_NO_PARITY;
        end
        hsbr_pkg::PH_PAR_END: begin
          w = wait_step(clk_lv);
          if (w == W_MET) begin
            if (par_bad) err_tally = err_tally + 8'd1;
            phase    = hsbr_pkg::PH_ACK;
            wait_cnt = ack_len;
          end
          abort_code = hsbr_pkg::ST_NO_END;
        end
        hsbr_pkg::PH_ACK: begin
          r.data_drive_low     = 1'b1;
          r.clock_drive_enable = 1'b1;
          r.clock_drive_value  = !par_bad;
          if (wait_cnt <= 1) begin
            phase           = hsbr_pkg::PH_IDLE;
            r.done_res      = 1'b1;
            r.status        = par_bad ? hsbr_pkg::ST_PARITY_ERR : hsbr_pkg::ST_OK;
            r.received_byte = shift_byte;
          end else begin
            wait_cnt = wait_cnt - 8'd1;
          end
        end
        default: phase = hsbr_pkg::PH_IDLE;
      endcase
      aborted = (w == W_EXPIRED);
      if (aborted) begin
        phase      = hsbr_pkg::PH_IDLE;
        r.done_res = 1'b1;
        r.status   = abort_code;
      end
      r.parity_error_count = err_tally;
      r.busy_res           = (phase != hsbr_pkg::PH_IDLE);
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_result(hsbr_pkg::hsbr_result_t got);
      hsbr_pkg::hsbr_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing pending", beats_checked));
      end else begin
        want = pending_q.pop_front();
        if (got.data_drive_low !== want.data_drive_low)
          report($sformatf("beat %0d data_drive_low got %0b want %0b", beats_checked,
                           got.data_drive_low, want.data_drive_low));
        if (got.clock_drive_enable !== want.clock_drive_enable)
          report($sformatf("beat %0d clock_drive_enable got %0b want %0b", beats_checked,
                           got.clock_drive_enable, want.clock_drive_enable));
        if (got.clock_drive_value !== want.clock_drive_value)
          report($sformatf("beat %0d clock_drive_value got %0b want %0b", beats_checked,
                           got.clock_drive_value, want.clock_drive_value));
        if (got.done_res !== want.done_res)
          report($sformatf("beat %0d done_res got %0b want %0b", beats_checked,
                           got.done_res, want.done_res));
        if (got.received_byte !== want.received_byte)
          report($sformatf("beat %0d received_byte got %0h want %0h", beats_checked,
                           got.received_byte, want.received_byte));
        if (got.status !== want.status)
          report($sformatf("beat %0d status got %0d want %0d", beats_checked,
                           got.status, want.status));
        if (got.parity_error_count !== want.parity_error_count)
          report($sformatf("beat %0d parity_error_count got %0d want %0d", beats_checked,
                           got.parity_error_count, want.parity_error_count));
        if (got.busy_res !== want.busy_res)
          report($sformatf("beat %0d busy_res got %0b want %0b", beats_checked,
                           got.busy_res, want.busy_res));
      end
      beats_checked++;
    endtask
  endclass

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_HALF, RDY_PERIODIC, RDY_HOLD} ready_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic       in_start_req;
  logic       in_clock_level;
  logic       in_data_level;
  logic       out_valid;
  logic       out_ready;
  logic       out_data_drive_low;
  logic       out_clock_drive_enable;
  logic       out_clock_drive_value;
  logic       out_done_res;
  logic [7:0] out_received_byte;
  logic [2:0] out_status;
  logic [7:0] out_parity_error_count;
  logic       out_busy_res;

  rx_byte_scoreboard #(DATA_BITS) sb;
  int burst_left = 0;
  int ticks_sent = 0;
  bit hold_req   = 1'b0;
  int cycle_cnt;

  handshake_serial_byte_receiver #(.DATA_BITS(DATA_BITS)) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_start_req           (in_start_req),
    .in_clock_level         (in_clock_level),
    .in_data_level          (in_data_level),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_data_drive_low     (out_data_drive_low),
    .out_clock_drive_enable (out_clock_drive_enable),
    .out_clock_drive_value  (out_clock_drive_value),
    .out_done_res           (out_done_res),
    .out_received_byte      (out_received_byte),
    .out_status             (out_status),
    .out_parity_error_count (out_parity_error_count),
    .out_busy_res           (out_busy_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin : beat_monitor
    hsbr_pkg::hsbr_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_tick(in_start_req, in_clock_level, in_data_level);
      if (out_valid && out_ready) begin
        got.data_drive_low     = out_data_drive_low;
        got.clock_drive_enable = out_clock_drive_enable;
        got.clock_drive_value  = out_clock_drive_value;
        got.done_res           = out_done_res;
        got.received_byte      = out_received_byte;
        got.status             = hsbr_pkg::hsbr_status_t'(out_status);
        got.parity_error_count = out_parity_error_count;
        got.busy_res           = out_busy_res;
        sb.check_result(got);
      end
    end
  end

  // Result side: windows of random stall patterns, and one long hold when asked.
  initial begin : ready_gen
    ready_mode_t mode;
    int          span_left;
    mode      = RDY_ALWAYS;
    span_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (span_left == 0) begin
        if (hold_req) begin
          mode      = RDY_HOLD;
          span_left = HOLD_CYCLES;
          hold_req  = 1'b0;
        end else begin
          mode      = ready_mode_t'($urandom_range(0, 3));
          span_left = $urandom_range(16, 64);
        end
      end
      span_left--;
      case (mode)
        RDY_ALWAYS:   out_ready <= 1'b1;
        RDY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
        RDY_HALF:     out_ready <= 1'($urandom_range(0, 1));
        RDY_PERIODIC: out_ready <= (span_left % 4 != 0);
        default:      out_ready <= 1'b0;
      endcase
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one tick beat and hold it until accepted; the sender idles between bursts.
  task automatic send_tick(input bit start, input bit clk_lv, input bit dat);
    int pause;
    if (burst_left == 0) begin
      pause = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_start_req   <= start;
    in_clock_level <= clk_lv;
    in_data_level  <= dat;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic level_run(input bit lvl, input int n, input bit first_dat, input bit tight);
    for (int i = 0; i < n; i++) begin
      send_tick(!tight && $urandom_range(0, 39) == 0, lvl,
                (i == 0) ? first_dat : 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic idle_run(input int n);
    repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic noise_run(input int n);
    repeat (n) send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
  endtask

  // Extra ticks of the wrong clock level at wait point w; enough to time out at abort_at.
  function automatic int wait_ticks(input int w, input int abort_at, input bit tight);
    int t;
    t = int'(sb.tmo_reload);
    if (w == abort_at) return t + 2;
    if (tight) return 0;
    if (t <= 24 && $urandom_range(0, 7) == 0) return $urandom_range(0, t + 2);
    return $urandom_range(0, (t < 3) ? t : 3);
  endfunction

  // One sender transfer: request, handshake, 8 bits LSB first, even parity, acknowledge.
  // Wait points: 0 request, 1 first bit, 2+2k bit k start, 3+2k bit k end (parity is k=8).
  task automatic send_transfer(input logic [7:0] data_byte, input bit bad_par,
                               input int abort_at, input bit tight);
    logic [8:0] frame;
    int         ack_eff;
    frame   = {(^data_byte) ^ bad_par, data_byte};
    ack_eff = (sb.ack_ticks == 0) ? 1 : int'(sb.ack_ticks);
    send_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    level_run(1'b1, wait_ticks(0, abort_at, tight), 1'b0, tight);
    if (abort_at == 0) begin
      idle_run(2);
      return;
    end
    level_run(1'b0, 1 + ack_eff + wait_ticks(1, abort_at, tight), 1'b1, tight);
    if (abort_at == 1) begin
      idle_run(2);
      return;
    end
    for (int k = 0; k < 9; k++) begin
      level_run(1'b1, 1 + wait_ticks(2 + 2 * k, abort_at, tight),
                1'($urandom_range(0, 1)), tight);
      if (abort_at == 2 + 2 * k) begin
        idle_run(2);
        return;
      end
      level_run(1'b0, 1 + wait_ticks(3 + 2 * k, abort_at, tight), frame[k], tight);
      if (abort_at == 3 + 2 * k) begin
        idle_run(2);
        return;
      end
    end
    // hold clock high through the acknowledge
    level_run(1'b1, 1 + ack_eff + $urandom_range(0, 2), 1'($urandom_range(0, 1)), 1'b1);
    idle_run($urandom_range(0, 3));
  endtask

  // Run any open attempt out, drop valid, and drain every pending result.
  task automatic quiesce();
    while (sb.busy()) send_tick(1'b0, sb.stall_level(), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_config(idx, val);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] tmo, input logic [7:0] ack, input int budget,
                           input bit squeeze);
    int stop_at;
    int abort_at;
    write_cfg(hsbr_pkg::CFG_TIMEOUT_RELOAD, tmo);
    write_cfg(hsbr_pkg::CFG_ACK_LOW_TICKS, ack);
    if (squeeze) hold_req = 1'b1;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        noise_run($urandom_range(5, 25));
      end else begin
        abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 19) : -1;
        send_transfer(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, abort_at, 1'b0);
      end
    end
    quiesce();
  endtask

  initial begin : stimulus
    int abort_points[6];
    sb = new();
    abort_points   = '{0, 1, 2, 9, 18, 19};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = hsbr_pkg::CFG_TIMEOUT_RELOAD;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_start_req   = 1'b0;
    in_clock_level = 1'b1;
    in_data_level  = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: byte extremes, a parity error, start while busy.
    send_transfer(8'h00, 1'b0, -1, 1'b1);
    send_transfer(8'hFF, 1'b0, -1, 1'b1);
    send_transfer(8'h96, 1'b1, -1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    quiesce();

    // Zero timeout and zero ack length: abort at each kind of wait, then a clean transfer.
    write_cfg(hsbr_pkg::CFG_TIMEOUT_RELOAD, 8'd0);
    write_cfg(hsbr_pkg::CFG_ACK_LOW_TICKS, 8'd0);
    foreach (abort_points[i])
      send_transfer(8'($urandom_range(0, 255)), 1'b0, abort_points[i], 1'b1);
    send_transfer(8'h5A, 1'b0, -1, 1'b1);
    quiesce();

    run_phase(8'd255, 8'd10, 100, 1'b1);
    run_phase(8'd3, 8'd1, 100, 1'b0);
    run_phase(8'd0, 8'd0, 80, 1'b0);
    run_phase(8'd1, 8'd2, 80, 1'b0);
    run_phase(8'd255, 8'd255, 40, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 40)), 80, 1'b0);
    run_phase(8'd12, 8'd4, 80, 1'b0);

    repeat (8) @(negedge clk);
    if (sb.pending_count() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.pending_count()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
